// File: rtl/ndm_pkg.sv
// Package for the nearest descriptor match unit.
// Holds sizes, codes, state encoding and the transfer payload structs.
// No dependencies.
package ndm_pkg;

    // Database geometry.
    localparam int DESCRIPTOR_LENGTH = 128;
    localparam int MAX_ENTRIES       = 64;

    // Fixed field widths.
    localparam int POS_W   = 7;
    localparam int ELEM_W  = 16;
    localparam int LABEL_W = 16;
    localparam int THR_W   = 39;
    localparam int DIST_W  = 40;
    localparam int SQ_W    = 2 * ELEM_W;

    // Derived widths.
    localparam int ENTRY_W    = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
    localparam int CNT_W      = $clog2(MAX_ENTRIES + 1);
    localparam int REF_DEPTH  = DESCRIPTOR_LENGTH * MAX_ENTRIES;
    localparam int REF_ADDR_W = $clog2(REF_DEPTH);

    // Saturation limits.
    localparam logic [DIST_W-1:0] DIST_MAX     = '1;
    localparam logic [THR_W-1:0]  OUT_DIST_MAX = '1;

    typedef enum logic [1:0] {
        KIND_LOAD  = 2'd0,
        KIND_QUERY = 2'd1,
        KIND_CLEAR = 2'd2
    } t_kind;

    typedef enum logic [1:0] {
        ST_DONE   = 2'd0,
        ST_EMPTY  = 2'd1,
        ST_STORED = 2'd2,
        ST_FULL   = 2'd3
    } t_status;

    typedef enum logic [2:0] {
        S_IDLE,
        S_ACC,
        S_SCAN,
        S_LABEL,
        S_EMIT
    } t_state;

    typedef struct packed {
        logic [1:0]               kind;
        logic [POS_W-1:0]         position;
        logic signed [ELEM_W-1:0] element_value;
        logic [LABEL_W-1:0]       entry_label;
        logic                     last_element;
    } t_in_item;

    typedef struct packed {
        logic               matched;
        logic [LABEL_W-1:0] match_label;
        logic [THR_W-1:0]   best_distance;
        t_status            status;
    } t_out_item;

endpackage

// File: rtl/nearest_descriptor_match_unit.sv
// Nearest descriptor match unit: reference database, squared distance
// accumulation with one shared multiply-accumulate unit, and nearest search.
// Depends on ndm_pkg.

// Channel  | Direction | Signals                                  | Carries
// ---------+-----------+------------------------------------------+----------------------
// input    | in        | i_in_valid, o_in_ready, i_in_data        | t_in_item
// result   | out       | o_out_valid, i_out_ready, o_out_data     | t_out_item
// config   | in        | i_cfg_valid, o_cfg_ready, i_cfg_data     | threshold_squared
//
// Load, clear and ignored items are handled in S_IDLE; a load's last element
// also passes through S_EMIT. During a query element the one multiply-accumulate
// unit visits each stored entry in turn; its last element then runs the nearest
// search, label read and result. Reset is synchronous and the memories need no
// clearing pass. Input is taken while a result waits, but a finished item stalls
// until the output register is free.
module nearest_descriptor_match_unit
    import ndm_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    output logic             o_in_ready,
    input  t_in_item         i_in_data,
    output logic             o_out_valid,
    input  logic             i_out_ready,
    output t_out_item        o_out_data,
    input  logic             i_cfg_valid,
    output logic             o_cfg_ready,
    input  logic [THR_W-1:0] i_cfg_data
);

    // Memories.
    logic [ELEM_W-1:0]  ref_mem  [REF_DEPTH];
    logic [LABEL_W-1:0] lab_mem  [MAX_ENTRIES];
    logic [DIST_W-1:0]  dist_mem [MAX_ENTRIES];

    // Control registers.
    t_state             r_state, n_state;
    logic [CNT_W-1:0]   r_count, n_count;
    logic [CNT_W-1:0]   r_idx, n_idx;
    logic               r_s1_vld, n_s1_vld;
    logic [ENTRY_W-1:0] r_s1_idx, n_s1_idx;
    logic               r_s2_vld, n_s2_vld;
    logic [MAX_ENTRIES-1:0] r_dvalid, n_dvalid;
    logic               r_last, n_last;
    t_status            r_status, n_status;
    logic [THR_W-1:0]   r_thr, n_thr;
    logic               r_o_valid, n_o_valid;

    // Payload registers.
    logic [POS_W-1:0]         r_pos, n_pos;
    logic signed [ELEM_W-1:0] r_elem, n_elem;
    logic [ENTRY_W-1:0]       r_s2_idx, n_s2_idx;
    logic [SQ_W-1:0]          r_sq, n_sq;
    logic [DIST_W-1:0]        r_s2_dist, n_s2_dist;
    logic [DIST_W-1:0]        r_best, n_best;
    logic [ENTRY_W-1:0]       r_best_idx, n_best_idx;
    t_out_item                r_o_data, n_o_data;

    // Registered memory read data.
    logic [ELEM_W-1:0]  r_ref_q;
    logic [DIST_W-1:0]  r_dist_q;
    logic               r_dval_q;
    logic [LABEL_W-1:0] r_lab_q;

    // Memory control and datapath signals.
    logic                     ref_we;
    logic [REF_ADDR_W-1:0]    ref_waddr;
    logic [REF_ADDR_W-1:0]    ref_raddr;
    logic [ENTRY_W-1:0]       rd_idx;
    logic                     lab_we;
    logic                     dist_we;
    logic [DIST_W-1:0]        acc_sat;
    logic [DIST_W:0]          acc_sum;
    logic signed [ELEM_W:0]   diff;
    logic [ELEM_W-1:0]        mag;
    logic [DIST_W-1:0]        cur_dist;
    logic                     pos_ok;
    logic                     room;
    logic                     idx_done;
    logic                     hit;
    t_out_item                res;

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = r_o_valid;
    assign o_out_data  = r_o_data;
    assign o_cfg_ready = 1'b1;

    // Address and compare helpers.
    assign pos_ok    = (32'(i_in_data.position) < DESCRIPTOR_LENGTH);
    assign room      = (r_count < CNT_W'(MAX_ENTRIES));
    assign idx_done  = (r_idx == r_count);
    assign rd_idx    = r_idx[ENTRY_W-1:0];
    assign ref_waddr = REF_ADDR_W'(r_count[ENTRY_W-1:0]) * REF_ADDR_W'(DESCRIPTOR_LENGTH)
                     + REF_ADDR_W'(i_in_data.position);
    assign ref_raddr = REF_ADDR_W'(rd_idx) * REF_ADDR_W'(DESCRIPTOR_LENGTH)
                     + REF_ADDR_W'(r_pos);

    // Shared multiply unit: squared difference of query and reference.
    assign diff     = {r_elem[ELEM_W-1], r_elem} - {r_ref_q[ELEM_W-1], r_ref_q};
    assign mag      = diff[ELEM_W] ? ELEM_W'(-diff) : ELEM_W'(diff);
    assign cur_dist = r_dval_q ? r_dist_q : '0;

    // Accumulate with saturation.
    assign acc_sum = {1'b0, r_s2_dist} + (DIST_W + 1)'(r_sq);
    assign acc_sat = acc_sum[DIST_W] ? DIST_MAX : acc_sum[DIST_W-1:0];

    // Result of a finished query or load.
    assign hit = (r_best < {1'b0, r_thr});
    always_comb begin
        res = '0;
        res.status = r_status;
        if (r_status == ST_DONE) begin
            res.matched       = hit;
            res.match_label   = hit ? r_lab_q : '0;
            res.best_distance = (r_best > DIST_W'(OUT_DIST_MAX)) ? OUT_DIST_MAX
                                                                 : r_best[THR_W-1:0];
        end
    end

    // Sequencer: next state and register values.
    always_comb begin
        n_state    = r_state;
        n_count    = r_count;
        n_idx      = r_idx;
        n_s1_vld   = 1'b0;
        n_s1_idx   = r_s1_idx;
        n_s2_vld   = 1'b0;
        n_s2_idx   = r_s2_idx;
        n_dvalid   = r_dvalid;
        n_last     = r_last;
        n_status   = r_status;
        n_thr      = r_thr;
        n_o_valid  = r_o_valid;
        n_pos      = r_pos;
        n_elem     = r_elem;
        n_sq       = r_sq;
        n_s2_dist  = r_s2_dist;
        n_best     = r_best;
        n_best_idx = r_best_idx;
        n_o_data   = r_o_data;
        ref_we     = 1'b0;
        lab_we     = 1'b0;
        dist_we    = 1'b0;

        // Configuration write.
        if (i_cfg_valid) begin
            n_thr = i_cfg_data;
        end

        // Result transfer frees the output register.
        if (r_o_valid && i_out_ready) begin
            n_o_valid = 1'b0;
        end

        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    n_pos  = i_in_data.position;
                    n_elem = i_in_data.element_value;
                    n_last = i_in_data.last_element;
                    n_idx  = '0;
                    case (i_in_data.kind)
                        KIND_LOAD: begin
                            ref_we = room && pos_ok;
                            if (i_in_data.last_element) begin
                                n_state = S_EMIT;
                                if (room) begin
                                    lab_we   = 1'b1;
                                    n_count  = r_count + CNT_W'(1);
                                    n_status = ST_STORED;
                                end else begin
                                    n_status = ST_FULL;
                                end
                            end
                        end
                        KIND_QUERY: begin
                            if (r_count == '0) begin
                                if (i_in_data.last_element) begin
                                    n_status = ST_EMPTY;
                                    n_state  = S_EMIT;
                                end
                            end else if (pos_ok) begin
                                n_state = S_ACC;
                            end else if (i_in_data.last_element) begin
                                n_state = S_SCAN;
                            end
                        end
                        KIND_CLEAR: begin
                            n_count  = '0;
                            n_dvalid = '0;
                        end
                        default: begin
                        end
                    endcase
                end
            end

            // One entry enters the multiply-accumulate pipeline per cycle.
            S_ACC: begin
                if (!idx_done) begin
                    n_s1_vld = 1'b1;
                    n_s1_idx = rd_idx;
                    n_idx    = r_idx + CNT_W'(1);
                end
                if (r_s1_vld) begin
                    n_s2_vld  = 1'b1;
                    n_s2_idx  = r_s1_idx;
                    n_sq      = SQ_W'(mag) * SQ_W'(mag);
                    n_s2_dist = cur_dist;
                end
                if (r_s2_vld) begin
                    dist_we = 1'b1;
                    n_dvalid[r_s2_idx] = 1'b1;
                end
                if (idx_done && !r_s1_vld && !r_s2_vld) begin
                    n_idx   = '0;
                    n_state = r_last ? S_SCAN : S_IDLE;
                end
            end

            // Nearest search; ties go to the later entry.
            S_SCAN: begin
                if (!idx_done) begin
                    n_s1_vld = 1'b1;
                    n_s1_idx = rd_idx;
                    n_idx    = r_idx + CNT_W'(1);
                end
                if (r_s1_vld && ((r_s1_idx == '0) || (cur_dist <= r_best))) begin
                    n_best     = cur_dist;
                    n_best_idx = r_s1_idx;
                end
                if (idx_done && !r_s1_vld) begin
                    n_status = ST_DONE;
                    n_state  = S_LABEL;
                end
            end

            // Label read of the nearest entry lands in r_lab_q.
            S_LABEL: begin
                n_state = S_EMIT;
            end

            S_EMIT: begin
                if (!r_o_valid || i_out_ready) begin
                    n_o_valid = 1'b1;
                    n_o_data  = res;
                    n_state   = S_IDLE;
                    if (r_status == ST_DONE) begin
                        n_dvalid = '0;
                    end
                end
            end

            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Control registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_count   <= '0;
            r_idx     <= '0;
            r_s1_vld  <= 1'b0;
            r_s1_idx  <= '0;
            r_s2_vld  <= 1'b0;
            r_dvalid  <= '0;
            r_last    <= 1'b0;
            r_status  <= ST_DONE;
            r_thr     <= '0;
            r_o_valid <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_count   <= n_count;
            r_idx     <= n_idx;
            r_s1_vld  <= n_s1_vld;
            r_s1_idx  <= n_s1_idx;
            r_s2_vld  <= n_s2_vld;
            r_dvalid  <= n_dvalid;
            r_last    <= n_last;
            r_status  <= n_status;
            r_thr     <= n_thr;
            r_o_valid <= n_o_valid;
        end
    end

    // Payload registers.
    always_ff @(posedge i_clk) begin
        r_pos      <= n_pos;
        r_elem     <= n_elem;
        r_s2_idx   <= n_s2_idx;
        r_sq       <= n_sq;
        r_s2_dist  <= n_s2_dist;
        r_best     <= n_best;
        r_best_idx <= n_best_idx;
        r_o_data   <= n_o_data;
    end

    // Reference store.
    always_ff @(posedge i_clk) begin
        if (ref_we) begin
            ref_mem[ref_waddr] <= i_in_data.element_value;
        end
        r_ref_q <= ref_mem[ref_raddr];
    end

    // Label store.
    always_ff @(posedge i_clk) begin
        if (lab_we) begin
            lab_mem[r_count[ENTRY_W-1:0]] <= i_in_data.entry_label;
        end
        r_lab_q <= lab_mem[r_best_idx];
    end

    // Running distance store; entries without a valid bit read as zero.
    always_ff @(posedge i_clk) begin
        if (dist_we) begin
            dist_mem[r_s2_idx] <= acc_sat;
        end
        r_dist_q <= dist_mem[rd_idx];
        r_dval_q <= r_dvalid[rd_idx];
    end

endmodule
